@@ rtl/tgr_pkg.sv @@
package tgr_pkg;

	localparam int MS_PER_S = 1000;

	localparam int CFG_IDX_BITS = 3;
	localparam int CFG_DATA_BITS = 16;

	localparam logic [CFG_IDX_BITS-1:0] CFG_DRAG_SLOP = 3'd0;
	localparam logic [CFG_IDX_BITS-1:0] CFG_LONG_PRESS = 3'd1;
	localparam logic [CFG_IDX_BITS-1:0] CFG_TAP_MAX = 3'd2;
	localparam logic [CFG_IDX_BITS-1:0] CFG_FLING_SPEED = 3'd3;
	localparam logic [CFG_IDX_BITS-1:0] CFG_FLING_GAP = 3'd4;

	localparam logic [9:0] RST_DRAG_SLOP = 10'd10;
	localparam logic [15:0] RST_LONG_PRESS = 16'd500;
	localparam logic [15:0] RST_TAP_MAX = 16'd300;
	localparam logic [14:0] RST_FLING_SPEED = 15'd200;
	localparam logic [15:0] RST_FLING_GAP = 16'd80;

	localparam int KIND_BITS = 3;
	localparam int SPEED_BITS = 16;

	typedef enum logic [KIND_BITS-1:0] {
		EV_DOWN = 3'd0,
		EV_MOVE = 3'd1,
		EV_LONG = 3'd2,
		EV_UP = 3'd3,
		EV_TAP = 3'd4,
		EV_FLING = 3'd5
	} event_kind_t;

	typedef struct packed {
		logic capture;
		logic eval;
		logic load0;
		logic load1;
	} ctrl_cmd_t;

	typedef struct packed {
		logic [1:0] nres;
		logic need_div;
		logic div_done;
		logic out_free;
	} dp_status_t;

endpackage

@@ rtl/tgr_ctrl.sv @@
module tgr_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                s_tvalid,
	output logic                s_tready,
	input  tgr_pkg::dp_status_t sts,
	output tgr_pkg::ctrl_cmd_t  cmd
);
	import tgr_pkg::*;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_EVAL,
		ST_DIV,
		ST_EMIT0,
		ST_EMIT1
	} state_t;

	state_t state_q;
	logic [1:0] nres_q;

	assign s_tready = (state_q == ST_IDLE);

	always_comb begin
		cmd.capture = (state_q == ST_IDLE) && s_tvalid;
		cmd.eval = (state_q == ST_EVAL);
		cmd.load0 = (state_q == ST_EMIT0) && sts.out_free;
		cmd.load1 = (state_q == ST_EMIT1) && sts.out_free;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			nres_q <= 2'd0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (s_tvalid)
						state_q <= ST_EVAL;
				end
				ST_EVAL: begin
					nres_q <= sts.nres;
					if (sts.nres == 2'd0)
						state_q <= ST_IDLE;
					else if (sts.need_div)
						state_q <= ST_DIV;
					else
						state_q <= ST_EMIT0;
				end
				ST_DIV: begin
					if (sts.div_done)
						state_q <= ST_EMIT0;
				end
				ST_EMIT0: begin
					if (sts.out_free)
						state_q <= (nres_q == 2'd2) ? ST_EMIT1 : ST_IDLE;
				end
				ST_EMIT1: begin
					if (sts.out_free)
						state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

endmodule

@@ rtl/tgr_dp.sv @@
module tgr_dp #(
	parameter int COORD_BITS = 10,
	parameter int TIME_BITS = 32
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  tgr_pkg::ctrl_cmd_t                   cmd,
	output tgr_pkg::dp_status_t                  sts,
	input  logic                                 cfg_we,
	input  logic [tgr_pkg::CFG_IDX_BITS-1:0]     cfg_index,
	input  logic [tgr_pkg::CFG_DATA_BITS-1:0]    cfg_wdata,
	input  logic                                 in_finger,
	input  logic [COORD_BITS-1:0]                in_x,
	input  logic [COORD_BITS-1:0]                in_y,
	input  logic [TIME_BITS-1:0]                 in_time,
	input  logic                                 m_tready,
	output logic                                 m_tvalid,
	output logic                                 m_tlast,
	output logic [tgr_pkg::KIND_BITS-1:0]        out_kind,
	output logic [COORD_BITS-1:0]                out_x,
	output logic [COORD_BITS-1:0]                out_y,
	output logic signed [COORD_BITS:0]           out_dx,
	output logic signed [COORD_BITS:0]           out_dy,
	output logic signed [tgr_pkg::SPEED_BITS-1:0] out_speed,
	output logic [TIME_BITS-1:0]                 out_time
);
	import tgr_pkg::*;

	localparam int DW = COORD_BITS + 1;
	localparam int NUM_BITS = COORD_BITS + 10;
	localparam int CNT_BITS = $clog2(NUM_BITS + 1);

	typedef enum logic [2:0] {
		BR_NONE,
		BR_DOWN,
		BR_LONG,
		BR_HOLD,
		BR_UP
	} branch_t;

	logic [9:0] drag_slop_q;
	logic [15:0] long_press_q;
	logic [15:0] tap_max_q;
	logic [14:0] fling_speed_q;
	logic [15:0] fling_gap_q;

	logic smp_f_q;
	logic [COORD_BITS-1:0] smp_x_q, smp_y_q;
	logic [TIME_BITS-1:0] smp_t_q;

	logic held_q, drag_q, lp_done_q;
	logic [COORD_BITS-1:0] press_x_q, press_y_q, prev_x_q, prev_y_q;
	logic [TIME_BITS-1:0] press_time_q, last_move_q;
	logic signed [SPEED_BITS-1:0] vspeed_q;

	event_kind_t res0_kind_q, res1_kind_q;
	logic [COORD_BITS-1:0] res0_x_q, res0_y_q, res1_x_q, res1_y_q;
	logic signed [DW-1:0] res0_dx_q, res0_dy_q;
	logic signed [SPEED_BITS-1:0] res1_speed_q;
	logic res0_last_q;

	logic out_valid_q;
	event_kind_t out_kind_q;
	logic [COORD_BITS-1:0] out_x_q, out_y_q;
	logic signed [DW-1:0] out_dx_q, out_dy_q;
	logic signed [SPEED_BITS-1:0] out_speed_q;
	logic [TIME_BITS-1:0] out_time_q;
	logic out_last_q;

	logic div_busy_q, div_fin_q, div_neg_q;
	logic [CNT_BITS-1:0] div_cnt_q;
	logic [NUM_BITS-1:0] div_num_q;
	logic [TIME_BITS-1:0] div_rem_q, div_dv_q;

	logic signed [DW-1:0] dx, dy, tdx, tdy;
	logic [DW-1:0] dy_mag, tdx_mag, tdy_mag;
	logic [TIME_BITS-1:0] el_press, el_move;
	logic exceed, drag_new, moved, long_ok, tap_ok, fling_ok;
	logic [SPEED_BITS:0] vs_ext, vs_mag;
	branch_t branch;
	logic [1:0] nres;
	logic is_move, need_div;
	event_kind_t kind0, kind1;

	logic [TIME_BITS:0] div_trial;
	logic div_bit;
	logic [TIME_BITS-1:0] div_rem_nx;
	logic [NUM_BITS-1:0] div_q_nx;
	logic signed [SPEED_BITS-1:0] sat_q;

	assign dx = $signed({1'b0, smp_x_q}) - $signed({1'b0, prev_x_q});
	assign dy = $signed({1'b0, smp_y_q}) - $signed({1'b0, prev_y_q});
	assign tdx = $signed({1'b0, smp_x_q}) - $signed({1'b0, press_x_q});
	assign tdy = $signed({1'b0, smp_y_q}) - $signed({1'b0, press_y_q});
	assign dy_mag = dy[DW-1] ? DW'(-dy) : dy;
	assign tdx_mag = tdx[DW-1] ? DW'(-tdx) : tdx;
	assign tdy_mag = tdy[DW-1] ? DW'(-tdy) : tdy;
	assign el_press = smp_t_q - press_time_q;
	assign el_move = smp_t_q - last_move_q;

	assign exceed = (16'(tdx_mag) > 16'(drag_slop_q)) || (16'(tdy_mag) > 16'(drag_slop_q));
	assign drag_new = drag_q || exceed;
	assign moved = (dx != '0) || (dy != '0);
	assign long_ok = !lp_done_q && (el_press >= TIME_BITS'(long_press_q));
	assign tap_ok = !lp_done_q && (el_press <= TIME_BITS'(tap_max_q));
	assign vs_ext = {vspeed_q[SPEED_BITS-1], vspeed_q};
	assign vs_mag = vspeed_q[SPEED_BITS-1] ? ((SPEED_BITS+1)'(0) - vs_ext) : vs_ext;
	assign fling_ok = (vs_mag > (SPEED_BITS+1)'(fling_speed_q)) &&
		(el_move < TIME_BITS'(fling_gap_q));

	always_comb begin
		branch = BR_NONE;
		nres = 2'd0;
		is_move = 1'b0;
		need_div = 1'b0;
		kind0 = EV_UP;
		kind1 = EV_TAP;
		if (smp_f_q && !held_q) begin
			branch = BR_DOWN;
			nres = 2'd1;
			kind0 = EV_DOWN;
		end else if (smp_f_q) begin
			if (!drag_q && !exceed && long_ok) begin
				branch = BR_LONG;
				nres = 2'd1;
				kind0 = EV_LONG;
			end else begin
				branch = BR_HOLD;
				if (drag_new && moved) begin
					nres = 2'd1;
					kind0 = EV_MOVE;
					is_move = 1'b1;
					need_div = (el_move != '0);
				end
			end
		end else if (held_q) begin
			branch = BR_UP;
			nres = 2'd1;
			if (drag_q) begin
				if (fling_ok) begin
					nres = 2'd2;
					kind1 = EV_FLING;
				end
			end else if (tap_ok) begin
				nres = 2'd2;
			end
		end
	end

	assign div_trial = {div_rem_q, div_num_q[NUM_BITS-1]};
	assign div_bit = (div_trial >= {1'b0, div_dv_q});
	assign div_rem_nx = div_bit ? TIME_BITS'(div_trial - {1'b0, div_dv_q})
		: div_trial[TIME_BITS-1:0];
	assign div_q_nx = {div_num_q[NUM_BITS-2:0], div_bit};

	always_comb begin
		if (div_neg_q)
			sat_q = (div_num_q > NUM_BITS'(32768)) ? 16'sh8000
				: $signed(16'd0 - div_num_q[SPEED_BITS-1:0]);
		else
			sat_q = (div_num_q > NUM_BITS'(32767)) ? 16'sh7FFF
				: $signed(div_num_q[SPEED_BITS-1:0]);
	end

	always_comb begin
		sts.nres = nres;
		sts.need_div = need_div;
		sts.div_done = !div_busy_q && !div_fin_q;
		sts.out_free = !out_valid_q || m_tready;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			drag_slop_q <= RST_DRAG_SLOP;
			long_press_q <= RST_LONG_PRESS;
			tap_max_q <= RST_TAP_MAX;
			fling_speed_q <= RST_FLING_SPEED;
			fling_gap_q <= RST_FLING_GAP;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_DRAG_SLOP: drag_slop_q <= cfg_wdata[9:0];
				CFG_LONG_PRESS: long_press_q <= cfg_wdata;
				CFG_TAP_MAX: tap_max_q <= cfg_wdata;
				CFG_FLING_SPEED: fling_speed_q <= cfg_wdata[14:0];
				CFG_FLING_GAP: fling_gap_q <= cfg_wdata;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			smp_f_q <= in_finger;
			smp_x_q <= in_x;
			smp_y_q <= in_y;
			smp_t_q <= in_time;
		end
		if (cmd.eval) begin
			res0_kind_q <= kind0;
			res1_kind_q <= kind1;
			res0_x_q <= (branch == BR_UP) ? prev_x_q : smp_x_q;
			res0_y_q <= (branch == BR_UP) ? prev_y_q : smp_y_q;
			res0_dx_q <= is_move ? dx : '0;
			res0_dy_q <= is_move ? dy : '0;
			res0_last_q <= (nres != 2'd2);
			res1_x_q <= prev_x_q;
			res1_y_q <= prev_y_q;
			res1_speed_q <= (kind1 == EV_FLING) ? vspeed_q : '0;
		end
		if (cmd.eval && need_div) begin
			div_num_q <= NUM_BITS'(dy_mag) * NUM_BITS'(MS_PER_S);
			div_rem_q <= '0;
			div_dv_q <= el_move;
			div_neg_q <= dy[DW-1];
		end else if (div_busy_q) begin
			div_num_q <= div_q_nx;
			div_rem_q <= div_rem_nx;
		end
		if (cmd.load0 || cmd.load1) begin
			out_kind_q <= cmd.load0 ? res0_kind_q : res1_kind_q;
			out_x_q <= cmd.load0 ? res0_x_q : res1_x_q;
			out_y_q <= cmd.load0 ? res0_y_q : res1_y_q;
			out_dx_q <= cmd.load0 ? res0_dx_q : '0;
			out_dy_q <= cmd.load0 ? res0_dy_q : '0;
			out_speed_q <= cmd.load0 ? '0 : res1_speed_q;
			out_last_q <= cmd.load0 ? res0_last_q : 1'b1;
			out_time_q <= smp_t_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			div_busy_q <= 1'b0;
			div_fin_q <= 1'b0;
			div_cnt_q <= '0;
		end else begin
			div_fin_q <= 1'b0;
			if (cmd.eval && need_div) begin
				div_busy_q <= 1'b1;
				div_cnt_q <= CNT_BITS'(NUM_BITS);
			end else if (div_busy_q) begin
				div_cnt_q <= div_cnt_q - 1'b1;
				if (div_cnt_q == CNT_BITS'(1)) begin
					div_busy_q <= 1'b0;
					div_fin_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			held_q <= 1'b0;
			drag_q <= 1'b0;
			lp_done_q <= 1'b0;
			press_x_q <= '0;
			press_y_q <= '0;
			prev_x_q <= '0;
			prev_y_q <= '0;
			press_time_q <= '0;
			last_move_q <= '0;
			vspeed_q <= '0;
		end else begin
			if (div_fin_q)
				vspeed_q <= sat_q;
			if (cmd.eval) begin
				case (branch)
					BR_DOWN: begin
						held_q <= 1'b1;
						drag_q <= 1'b0;
						lp_done_q <= 1'b0;
						press_x_q <= smp_x_q;
						press_y_q <= smp_y_q;
						prev_x_q <= smp_x_q;
						prev_y_q <= smp_y_q;
						press_time_q <= smp_t_q;
						last_move_q <= smp_t_q;
						vspeed_q <= '0;
					end
					BR_LONG: begin
						lp_done_q <= 1'b1;
						prev_x_q <= smp_x_q;
						prev_y_q <= smp_y_q;
					end
					BR_HOLD: begin
						drag_q <= drag_new;
						prev_x_q <= smp_x_q;
						prev_y_q <= smp_y_q;
						if (is_move)
							last_move_q <= smp_t_q;
					end
					BR_UP: begin
						held_q <= 1'b0;
						drag_q <= 1'b0;
						lp_done_q <= 1'b0;
					end
					default: ;
				endcase
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid_q <= 1'b0;
		else if (cmd.load0 || cmd.load1)
			out_valid_q <= 1'b1;
		else if (m_tready)
			out_valid_q <= 1'b0;
	end

	assign m_tvalid = out_valid_q;
	assign m_tlast = out_last_q;
	assign out_kind = out_kind_q;
	assign out_x = out_x_q;
	assign out_y = out_y_q;
	assign out_dx = out_dx_q;
	assign out_dy = out_dy_q;
	assign out_speed = out_speed_q;
	assign out_time = out_time_q;

endmodule

@@ rtl/touch_gesture_recognizer_unit.sv @@
// Touch gesture recognizer: each input request is one poll sample (finger flag
// in s_tuser; x, y and millisecond time in s_tdata) and yields zero, one or two
// event requests (down, move, long press, up, tap, fling) with m_tlast on the
// final event of a sample. One sample is handled at a time: it is captured,
// then evaluated, and each of its events is then loaded into the output
// register, waiting while that register stays full; a drag move with nonzero
// elapsed time first runs the bit-serial restoring divider that computes the
// vertical velocity. The next sample is taken while the last event of the
// previous one still waits in the output register. The user must write the
// configuration registers through cfg_we/cfg_index/cfg_wdata only while no
// sample is in progress; the block itself does not enforce this.
module touch_gesture_recognizer_unit #(
	parameter int COORD_BITS = 10,
	parameter int TIME_BITS = 32
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_we,
	input  logic [tgr_pkg::CFG_IDX_BITS-1:0]  cfg_index,
	input  logic [tgr_pkg::CFG_DATA_BITS-1:0] cfg_wdata,
	input  logic                              s_tvalid,
	output logic                              s_tready,
	// touch_x, touch_y, now_ms
	input  logic [((2*COORD_BITS+TIME_BITS+7)/8)*8-1:0] s_tdata,
	// finger_present
	input  logic                              s_tuser,
	output logic                              m_tvalid,
	input  logic                              m_tready,
	// event_kind, event_x, event_y, move_dx, move_dy, fling_speed, event_time
	output logic [((4*COORD_BITS+TIME_BITS+21+7)/8)*8-1:0] m_tdata,
	output logic                              m_tlast
);
	import tgr_pkg::*;

	localparam int OUT_W = ((4*COORD_BITS+TIME_BITS+21+7)/8)*8;

	ctrl_cmd_t cmd;
	dp_status_t sts;

	logic [KIND_BITS-1:0] out_kind;
	logic [COORD_BITS-1:0] out_x, out_y;
	logic signed [COORD_BITS:0] out_dx, out_dy;
	logic signed [SPEED_BITS-1:0] out_speed;
	logic [TIME_BITS-1:0] out_time;

	tgr_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.sts      (sts),
		.cmd      (cmd)
	);

	tgr_dp #(
		.COORD_BITS (COORD_BITS),
		.TIME_BITS  (TIME_BITS)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.sts       (sts),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata),
		.in_finger (s_tuser),
		.in_x      (s_tdata[COORD_BITS-1:0]),
		.in_y      (s_tdata[2*COORD_BITS-1:COORD_BITS]),
		.in_time   (s_tdata[2*COORD_BITS+TIME_BITS-1:2*COORD_BITS]),
		.m_tready  (m_tready),
		.m_tvalid  (m_tvalid),
		.m_tlast   (m_tlast),
		.out_kind  (out_kind),
		.out_x     (out_x),
		.out_y     (out_y),
		.out_dx    (out_dx),
		.out_dy    (out_dy),
		.out_speed (out_speed),
		.out_time  (out_time)
	);

	assign m_tdata = OUT_W'({out_time, out_speed, out_dy, out_dx, out_y, out_x, out_kind});

endmodule

@@ rtl/tgr_checker.sv @@
module tgr_checker #(
	parameter int COORD_BITS = 10,
	parameter int TIME_BITS = 32
) (
	input logic                              clk,
	input logic                              arst_n,
	input logic                              s_tvalid,
	input logic                              s_tready,
	input logic                              m_tvalid,
	input logic                              m_tready,
	input logic [((4*COORD_BITS+TIME_BITS+21+7)/8)*8-1:0] m_tdata,
	input logic                              m_tlast
);
	import tgr_pkg::*;

	localparam int DX_LO = KIND_BITS + 2*COORD_BITS;
	localparam int DY_LO = DX_LO + COORD_BITS + 1;
	localparam int SP_LO = DY_LO + COORD_BITS + 1;

	logic [KIND_BITS-1:0] kind;
	logic [COORD_BITS:0] dx, dy;
	logic [SPEED_BITS-1:0] speed;

	assign kind = m_tdata[KIND_BITS-1:0];
	assign dx = m_tdata[DY_LO-1:DX_LO];
	assign dy = m_tdata[SP_LO-1:DY_LO];
	assign speed = m_tdata[SP_LO+SPEED_BITS-1:SP_LO];

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
		else $error("stalled event request changed");

	a_run_blocks_input: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tlast |-> !s_tready)
		else $error("sample taken before its event run finished");

	a_one_sample: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !s_tready)
		else $error("second sample taken while one is in progress");

	a_unused_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (kind == EV_MOVE || (dx == '0 && dy == '0)) &&
			(kind == EV_FLING || speed == '0))
		else $error("unused event fields not zero");

endmodule

bind touch_gesture_recognizer_unit tgr_checker #(
	.COORD_BITS (COORD_BITS),
	.TIME_BITS  (TIME_BITS)
) u_tgr_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tvalid (s_tvalid),
	.s_tready (s_tready),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata),
	.m_tlast  (m_tlast)
);

@@ test/testbench.sv @@
module testbench;
	import tgr_pkg::*;

	localparam int QUIET_LIMIT = 3000;
	localparam int SETTLE_CYCLES = 40;
	localparam logic [CFG_IDX_BITS-1:0] CFG_SPARE_FIRST = CFG_FLING_GAP + 1'b1;

	typedef struct {
		event_kind_t kind;
		bit [9:0]    x;
		bit [9:0]    y;
		bit [10:0]   dx;
		bit [10:0]   dy;
		bit [15:0]   speed;
		bit [31:0]   stamp;
		bit          last;
	} touch_event_t;

	logic        clk;
	logic        arst_n = 1'b0;
	logic        cfg_we = 1'b0;
	logic [2:0]  cfg_index = '0;
	logic [15:0] cfg_wdata = '0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [55:0] s_tdata = '0;
	logic        s_tuser = 1'b0;
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [95:0] m_tdata;
	logic        m_tlast;

	touch_event_t pending_events[$];

	// gesture tracker state and its copy of the registers
	bit        held, dragging, long_done;
	bit [9:0]  press_x, press_y, last_x, last_y;
	bit [31:0] press_t, last_move_t;
	int        speed_est;
	bit [9:0]  slop_px;
	bit [15:0] long_ms, tap_ms, gap_ms;
	bit [14:0] fling_speed_min;

	int        mismatch_count = 0;
	int        samples_sent = 0;
	int        events_checked = 0;
	int        settings_loaded = 0;
	int        kind_seen[6] = '{default: 0};
	int        gap_pct = 0;
	int        stall_pct = 0;
	int        stall_left = 0;
	int        quiet_cycles = 0;
	bit [31:0] clock_ms;

	touch_gesture_recognizer_unit dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_wdata(cfg_wdata),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.s_tuser(s_tuser),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata),
		.m_tlast(m_tlast)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	function automatic void push_event(event_kind_t kind, bit [9:0] x, bit [9:0] y,
			int dx, int dy, int speed, bit [31:0] stamp);
		touch_event_t ev;
		ev.kind = kind;
		ev.x = x;
		ev.y = y;
		ev.dx = dx[10:0];
		ev.dy = dy[10:0];
		ev.speed = speed[15:0];
		ev.stamp = stamp;
		ev.last = 1'b0;
		pending_events.push_back(ev);
	endfunction

	function automatic void predict_events(bit finger, bit [9:0] x, bit [9:0] y, bit [31:0] now);
		int        dx, dy, tdx, tdy, first;
		longint    q;
		bit [31:0] dt;
		first = pending_events.size();
		if (!finger && !held)
			return;
		if (finger && !held) begin
			held = 1'b1;
			dragging = 1'b0;
			long_done = 1'b0;
			press_x = x;
			press_y = y;
			last_x = x;
			last_y = y;
			press_t = now;
			last_move_t = now;
			speed_est = 0;
			push_event(EV_DOWN, x, y, 0, 0, 0, now);
		end else if (finger) begin
			dx = int'(x) - int'(last_x);
			dy = int'(y) - int'(last_y);
			if (!dragging) begin
				tdx = int'(x) - int'(press_x);
				tdy = int'(y) - int'(press_y);
				if (tdx < 0)
					tdx = -tdx;
				if (tdy < 0)
					tdy = -tdy;
				if (tdx > int'(slop_px) || tdy > int'(slop_px)) begin
					dragging = 1'b1;
				end else if (!long_done && (now - press_t) >= 32'(long_ms)) begin
					long_done = 1'b1;
					last_x = x;
					last_y = y;
					push_event(EV_LONG, x, y, 0, 0, 0, now);
					pending_events[$].last = 1'b1;
					return;
				end
			end
			if (dragging && (dx != 0 || dy != 0)) begin
				dt = now - last_move_t;
				if (dt != 0) begin
					q = (longint'(dy) * longint'(MS_PER_S)) / longint'(dt);
					if (q > 32767)
						q = 32767;
					if (q < -32768)
						q = -32768;
					speed_est = int'(q);
				end
				push_event(EV_MOVE, x, y, dx, dy, 0, now);
				last_move_t = now;
			end
			last_x = x;
			last_y = y;
		end else begin
			held = 1'b0;
			push_event(EV_UP, last_x, last_y, 0, 0, 0, now);
			if (dragging) begin
				if ((speed_est < 0 ? -speed_est : speed_est) > int'(fling_speed_min) &&
						(now - last_move_t) < 32'(gap_ms))
					push_event(EV_FLING, last_x, last_y, 0, 0, speed_est, now);
			end else if (!long_done && (now - press_t) <= 32'(tap_ms)) begin
				push_event(EV_TAP, last_x, last_y, 0, 0, 0, now);
			end
			dragging = 1'b0;
			long_done = 1'b0;
		end
		if (pending_events.size() > first)
			pending_events[$].last = 1'b1;
	endfunction

	task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
		$display("MISMATCH at %0t, event %0d, %s: got %0h, expected %0h",
			$realtime, events_checked, what, got, want);
		mismatch_count++;
	endtask

	task automatic check_event(logic [95:0] data, logic last);
		touch_event_t want;
		if (pending_events.size() == 0) begin
			report_mismatch("event with none pending, kind", 32'(data[2:0]), '0);
			return;
		end
		want = pending_events.pop_front();
		events_checked++;
		kind_seen[want.kind]++;
		if (data[2:0] !== want.kind)
			report_mismatch("event_kind", 32'(data[2:0]), 32'(want.kind));
		if (data[12:3] !== want.x)
			report_mismatch("event_x", 32'(data[12:3]), 32'(want.x));
		if (data[22:13] !== want.y)
			report_mismatch("event_y", 32'(data[22:13]), 32'(want.y));
		if (data[33:23] !== want.dx)
			report_mismatch("move_dx", 32'(data[33:23]), 32'(want.dx));
		if (data[44:34] !== want.dy)
			report_mismatch("move_dy", 32'(data[44:34]), 32'(want.dy));
		if (data[60:45] !== want.speed)
			report_mismatch("fling_speed", 32'(data[60:45]), 32'(want.speed));
		if (data[92:61] !== want.stamp)
			report_mismatch("event_time", data[92:61], want.stamp);
		if (last !== want.last)
			report_mismatch("last_of_run", 32'(last), 32'(want.last));
	endtask

	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready)
			check_event(m_tdata, m_tlast);
	end

	always @(posedge clk) begin
		if (stall_left > 0) begin
			m_tready <= 1'b0;
			stall_left--;
		end else if (stall_pct > 0 && $urandom_range(0, 99) < stall_pct) begin
			m_tready <= 1'b0;
			stall_left = $urandom_range(0, 8);
		end else begin
			m_tready <= 1'b1;
		end
	end

	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
			quiet_cycles = 0;
		end else begin
			quiet_cycles++;
			if (quiet_cycles >= QUIET_LIMIT) begin
				$display("Timeout: no request moved for %0d cycles, %0d events pending",
					QUIET_LIMIT, pending_events.size());
				$display("Test completed with failures");
				$finish;
			end
		end
	end

	task automatic send_sample(bit finger, bit [9:0] x, bit [9:0] y, bit [31:0] now);
		if (gap_pct > 0 && $urandom_range(0, 99) < gap_pct) begin
			s_tvalid <= 1'b0;
			repeat ($urandom_range(1, 9)) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser <= finger;
		s_tdata <= {4'b0, now, y, x};
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
		predict_events(finger, x, y, now);
		samples_sent++;
	endtask

	task automatic quiesce(int settle);
		s_tvalid <= 1'b0;
		while (pending_events.size() != 0)
			@(posedge clk);
		repeat (settle) @(posedge clk);
	endtask

	task automatic write_reg(logic [CFG_IDX_BITS-1:0] idx, logic [CFG_DATA_BITS-1:0] value);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= value;
		@(posedge clk);
		case (idx)
			CFG_DRAG_SLOP:   slop_px = value[9:0];
			CFG_LONG_PRESS:  long_ms = value;
			CFG_TAP_MAX:     tap_ms = value;
			CFG_FLING_SPEED: fling_speed_min = value[14:0];
			CFG_FLING_GAP:   gap_ms = value;
			default: ;
		endcase
		cfg_we <= 1'b0;
		@(posedge clk);
	endtask

	task automatic load_settings(bit [9:0] slop, bit [15:0] lp, bit [15:0] tap,
			bit [14:0] spd, bit [15:0] gap);
		quiesce(SETTLE_CYCLES);
		// upper bits of the narrow registers must be dropped
		write_reg(CFG_DRAG_SLOP, {6'($urandom), slop});
		write_reg(CFG_LONG_PRESS, lp);
		write_reg(CFG_TAP_MAX, tap);
		write_reg(CFG_FLING_SPEED, {1'($urandom), spd});
		write_reg(CFG_FLING_GAP, gap);
		for (int i = int'(CFG_SPARE_FIRST); i < (1 << CFG_IDX_BITS); i++)
			write_reg(CFG_IDX_BITS'(i), CFG_DATA_BITS'($urandom));
		settings_loaded++;
	endtask

	function automatic bit [31:0] pick_gap_ms();
		int r;
		r = $urandom_range(0, 99);
		if (r < 10)
			return 0;
		if (r < 75)
			return $urandom_range(1, 30);
		if (r < 96)
			return $urandom_range(100, 700);
		return $urandom;
	endfunction

	function automatic bit [9:0] step_coord(bit [9:0] c);
		int r, mag, v;
		r = $urandom_range(0, 99);
		if (r < 30)
			return c;
		if (r < 97) begin
			mag = (r < 65) ? 12 : 200;
			v = int'(c) + $urandom_range(0, 2 * mag) - mag;
		end else begin
			v = $urandom_range(0, 1) ? 1023 : 0;
		end
		if (v < 0)
			v = 0;
		if (v > 1023)
			v = 1023;
		return v[9:0];
	endfunction

	task automatic run_gesture(int max_moves);
		bit [9:0] x, y;
		int       moves;
		x = 10'($urandom);
		y = 10'($urandom);
		moves = $urandom_range(0, max_moves);
		clock_ms += pick_gap_ms();
		send_sample(1'b1, x, y, clock_ms);
		for (int i = 0; i < moves; i++) begin
			clock_ms += pick_gap_ms();
			x = step_coord(x);
			y = step_coord(y);
			send_sample(1'b1, x, y, clock_ms);
		end
		clock_ms += pick_gap_ms();
		send_sample(1'b0, 10'($urandom), 10'($urandom), clock_ms);
	endtask

	task automatic send_noise(int count);
		repeat (count)
			send_sample(1'($urandom_range(0, 1)), 10'($urandom), 10'($urandom), $urandom);
	endtask

	task automatic test_directed();
		bit [31:0] t;
		t = 32'h0000_1000;
		send_sample(1'b0, 10'h3FF, 10'h3FF, t);
		send_sample(1'b1, 10'd0, 10'd0, t);
		send_sample(1'b0, 10'd0, 10'd0, t + 300);
		t = 32'hA5A5_0000;
		send_sample(1'b1, 10'd1023, 10'd1023, t);
		send_sample(1'b1, 10'd1023, 10'd1013, t + 499);
		send_sample(1'b1, 10'd1023, 10'd1023, t + 500);
		send_sample(1'b1, 10'd1023, 10'd1023, t + 900);
		send_sample(1'b0, 10'd0, 10'd0, t + 1000);
		send_sample(1'b1, 10'd512, 10'd512, t + 2000);
		send_sample(1'b0, 10'd512, 10'd512, t + 2301);
		t = 32'h5A5A_0000;
		send_sample(1'b1, 10'd100, 10'd100, t);
		send_sample(1'b1, 10'd110, 10'd90, t + 3);
		send_sample(1'b1, 10'd111, 10'd100, t + 7);
		send_sample(1'b1, 10'd111, 10'd100, t + 9);
		send_sample(1'b1, 10'd111, 10'd120, t + 9);
		send_sample(1'b0, 10'd0, 10'd0, t + 89);
		t = 32'h7FFF_FFF0;
		send_sample(1'b1, 10'd500, 10'd0, t);
		send_sample(1'b1, 10'd500, 10'd1023, t + 1);
		send_sample(1'b1, 10'd500, 10'd0, t + 2);
		send_sample(1'b0, 10'd0, 10'd0, t + 3);
		send_sample(1'b1, 10'd7, 10'd9, 32'hFFFF_FFF0);
		send_sample(1'b0, 10'd0, 10'd0, 32'h0000_0010);
	endtask

	task automatic test_register_extremes();
		bit [31:0] t;
		load_settings('0, '0, '0, '0, '0);
		repeat (5) run_gesture(5);
		send_noise(3);
		load_settings('1, '1, '1, '1, '1);
		repeat (5) run_gesture(5);
		send_noise(3);
		// full-scale speeds against the largest threshold
		load_settings('0, '1, '0, '1, '1);
		t = 32'h0001_0000;
		send_sample(1'b1, 10'd300, 10'd1023, t);
		send_sample(1'b1, 10'd300, 10'd0, t + 1);
		send_sample(1'b0, 10'd0, 10'd0, t + 2);
		send_sample(1'b1, 10'd300, 10'd0, t + 10);
		send_sample(1'b1, 10'd300, 10'd1023, t + 11);
		send_sample(1'b0, 10'd0, 10'd0, t + 12);
		repeat (3) run_gesture(5);
		load_settings(10'($urandom), 16'($urandom), 16'($urandom), 15'($urandom),
			16'($urandom));
		repeat (4) run_gesture(5);
		send_noise(2);
	endtask

	task automatic test_random_gestures();
		int start;
		for (int phase = 0; phase < 4; phase++) begin
			case (phase)
				0: begin gap_pct = 30; stall_pct = 30; end
				1: begin gap_pct = 0;  stall_pct = 50; end
				2: begin gap_pct = 50; stall_pct = 0;  end
				default: begin gap_pct = 20; stall_pct = 20; end
			endcase
			if ($urandom_range(0, 3) == 0)
				load_settings(10'($urandom), 16'($urandom), 16'($urandom), 15'($urandom),
					16'($urandom));
			else
				load_settings(10'($urandom_range(0, 40)), 16'($urandom_range(100, 900)),
					16'($urandom_range(50, 500)), 15'($urandom_range(0, 3000)),
					16'($urandom_range(10, 200)));
			start = samples_sent;
			while (samples_sent - start < 70) begin
				if (phase == 2 && samples_sent - start >= 35 && samples_sent - start < 40)
					quiesce(0);
				if ($urandom_range(0, 99) < 85)
					run_gesture(6);
				else
					send_noise($urandom_range(1, 3));
			end
		end
	endtask

	task automatic test_back_to_back();
		gap_pct = 0;
		stall_pct = 0;
		load_settings(RST_DRAG_SLOP, RST_LONG_PRESS, RST_TAP_MAX, RST_FLING_SPEED,
			RST_FLING_GAP);
		repeat (8) run_gesture(5);
		send_noise(4);
	endtask

	initial begin
		held = 1'b0;
		dragging = 1'b0;
		long_done = 1'b0;
		press_x = '0;
		press_y = '0;
		last_x = '0;
		last_y = '0;
		press_t = '0;
		last_move_t = '0;
		speed_est = 0;
		slop_px = RST_DRAG_SLOP;
		long_ms = RST_LONG_PRESS;
		tap_ms = RST_TAP_MAX;
		fling_speed_min = RST_FLING_SPEED;
		gap_ms = RST_FLING_GAP;
		clock_ms = $urandom;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		gap_pct = 25;
		stall_pct = 25;
		test_directed();
		test_register_extremes();
		test_random_gestures();
		test_back_to_back();
		quiesce(SETTLE_CYCLES);
		$display("Sent %0d touch samples under %0d register settings, checked %0d events",
			samples_sent, settings_loaded + 1, events_checked);
		$display("Events by kind: down %0d, move %0d, long press %0d, up %0d, tap %0d, fling %0d",
			kind_seen[EV_DOWN], kind_seen[EV_MOVE], kind_seen[EV_LONG],
			kind_seen[EV_UP], kind_seen[EV_TAP], kind_seen[EV_FLING]);
		if (mismatch_count == 0 && pending_events.size() == 0) begin
			$display("Test completed successfully");
		end else begin
			$display("Test completed with failures");
		end
		$finish;
	end

endmodule
